// ===== hw/rtl/sobel_gradient_direction_macros.svh =====
// Assertion macros shared by the Sobel gradient RTL.
`ifndef SOBEL_GRADIENT_DIRECTION_MACROS_SVH
`define SOBEL_GRADIENT_DIRECTION_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SGD_ASSERT_IMPLIES(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("sobel gradient: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define SGD_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("sobel gradient: next-cycle check failed");

`endif

// ===== hw/rtl/sgd_pkg.sv =====
// Shared constants and types of the Sobel gradient block.
package sgd_pkg;

    // Line store geometry.
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);

    // Field and register widths.
    localparam int PIX_W      = 8;
    localparam int MAG_W      = 8;
    localparam int DIR_W      = 3;
    localparam int IMG_W_W    = 11;
    localparam int ROW_W      = 12;
    localparam int CFG_DATA_W = 12;

    // Register reset values.
    localparam int IMG_W_RESET = 640;
    localparam int IMG_H_RESET = 480;

    // Smallest image side that still has an interior pixel.
    localparam int MIN_SIDE = 3;

    // tan(22.5) and tan(67.5) with 16 fraction bits.
    localparam int TAN22_Q16 = 27146;
    localparam int TAN67_Q16 = 158218;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

endpackage

// ===== hw/rtl/sgd_ifs.sv =====
// Stream interfaces for the pixel input and the gradient result output.
interface sgd_pixel_if;
    import sgd_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic             frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface sgd_result_if;
    import sgd_pkg::*;

    logic             valid;
    logic             ready;
    logic [MAG_W-1:0] magnitude;
    logic [DIR_W-1:0] direction;
    logic             last_of_frame;

    modport source (output valid, output magnitude, output direction,
                    output last_of_frame, input ready);
    modport sink (input valid, input magnitude, input direction,
                  input last_of_frame, output ready);
endinterface

// ===== hw/rtl/sgd_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module sgd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    // A read at the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/sobel_gradient_direction.sv =====
// Top level of the Sobel gradient magnitude and direction sector pipeline.
//
//  channel  | role   | payload                                 | accepted when
//  ---------+--------+-----------------------------------------+----------------------
//  pixels   | sink   | pixel[7:0], frame_start                 | valid && ready
//  results  | source | magnitude[7:0], direction[2:0], last    | valid && ready
//  cfg      | write  | cfg_index (0 width, 1 height), data[11:0] | cfg_we
//
// One pixel is taken every cycle unless the result channel stalls a full pipe; each result
// travels through stages one to seven behind its pixel. The stages hold the line store read, the
// window adders, the two 8x8 squares, and the square root, which runs three digit steps a stage.
// Line stores hold no reset pass: a fill mark tracks the columns written since
// reset, and entries beyond it read as zero. Each stage holds when the stage
// after it is full and stalled, so bubbles close up and nothing is lost.
`include "sobel_gradient_direction_macros.svh"

module sobel_gradient_direction (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  sgd_pkg::cfg_index_t             cfg_index,
    input  logic [sgd_pkg::CFG_DATA_W-1:0]  cfg_data,
    sgd_pixel_if.sink                       pixels,
    sgd_result_if.source                    results
);
    import sgd_pkg::*;

    localparam int EW    = COL_W + 1;
    localparam int SUM_W = 17;
    localparam int SQ_W  = 2 * PIX_W;
    localparam int P22_W = 23;
    localparam int P67_W = 26;
    localparam int LHS_W = PIX_W + 16;

    // Direction sectors, counterclockwise from the positive x axis.
    localparam logic [DIR_W-1:0] SECTOR_E  = 3'd0;
    localparam logic [DIR_W-1:0] SECTOR_NE = 3'd1;
    localparam logic [DIR_W-1:0] SECTOR_N  = 3'd2;
    localparam logic [DIR_W-1:0] SECTOR_NW = 3'd3;
    localparam logic [DIR_W-1:0] SECTOR_W  = 3'd4;
    localparam logic [DIR_W-1:0] SECTOR_SW = 3'd5;
    localparam logic [DIR_W-1:0] SECTOR_S  = 3'd6;
    localparam logic [DIR_W-1:0] SECTOR_SE = 3'd7;

    typedef struct packed {
        logic [SUM_W-1:0] rem;
        logic [SUM_W-1:0] root;
    } sqrt_t;

    // Three digit steps of the bitwise square root, starting at digit first.
    function automatic sqrt_t sqrt_steps(input sqrt_t acc_in, input int first);
        sqrt_t          acc;
        logic [SUM_W-1:0] bitv;
        logic [SUM_W:0]   trial;
        acc = acc_in;
        for (int j = 0; j < 3; j++)
        begin
            bitv  = SUM_W'(1) << (16 - 2 * (first + j));
            trial = {1'b0, acc.root} + {1'b0, bitv};
            if ({1'b0, acc.rem} >= trial)
            begin
                acc.rem  = acc.rem - trial[SUM_W-1:0];
                acc.root = (acc.root >> 1) + bitv;
            end
            else
            begin
                acc.root = acc.root >> 1;
            end
        end
        return acc;
    endfunction

    // Configuration, held already clamped to the usable range.
    logic [EW-1:0]    w_eff_reg, w_eff_next;
    logic [ROW_W-1:0] h_eff_reg, h_eff_next;
    logic [IMG_W_W-1:0] w_cfg;
    logic [ROW_W-1:0]   h_cfg;

    always_comb
    begin
        w_cfg = cfg_data[IMG_W_W-1:0];
        h_cfg = cfg_data[ROW_W-1:0];
        if (32'(w_cfg) < MIN_SIDE)
        begin
            w_eff_next = EW'(MIN_SIDE);
        end
        else if (32'(w_cfg) > MAX_WIDTH)
        begin
            w_eff_next = EW'(MAX_WIDTH);
        end
        else
        begin
            w_eff_next = EW'(w_cfg);
        end
        if (32'(h_cfg) < MIN_SIDE)
        begin
            h_eff_next = ROW_W'(MIN_SIDE);
        end
        else
        begin
            h_eff_next = h_cfg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_eff_reg <= EW'(IMG_W_RESET);
            h_eff_reg <= ROW_W'(IMG_H_RESET);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  w_eff_reg <= w_eff_next;
                CFG_IMAGE_HEIGHT: h_eff_reg <= h_eff_next;
            endcase
        end
    end

    // Stage valids and the load chain: a stage loads when it is empty or its
    // contents move on.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic load1, load2, load3, load4, load5, load6, load7;
    logic accept, s1_leave;

    assign load7    = !v7_reg || results.ready;
    assign load6    = !v6_reg || load7;
    assign load5    = !v5_reg || load6;
    assign load4    = !v4_reg || load5;
    assign load3    = !v3_reg || load4;
    assign load2    = !v2_reg || load3;
    assign load1    = !v1_reg || load2;
    assign accept   = pixels.valid && load1;
    assign s1_leave = v1_reg && load1;
    assign pixels.ready = load1;

    // Position counters and the fill mark of the line stores.
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [EW-1:0]    hiwater_reg, hiwater_next;
    logic [EW-1:0]    c_start, c_wrap, c_inc;
    logic [ROW_W:0]   r_start, r_wrap, r_inc;
    logic [COL_W-1:0] c_pos;
    logic [ROW_W-1:0] r_pos;
    logic             res_flag, last_flag, entry_ok, fwd_hit;
    logic [COL_W-1:0] c1_reg;

    always_comb
    begin
        c_start = pixels.frame_start ? '0 : {1'b0, col_reg};
        r_start = pixels.frame_start ? '0 : {1'b0, row_reg};
        // A column at or past the width starts a new row.
        if (c_start >= w_eff_reg)
        begin
            c_wrap = '0;
            r_wrap = r_start + 1'b1;
        end
        else
        begin
            c_wrap = c_start;
            r_wrap = r_start;
        end
        if (r_wrap >= {1'b0, h_eff_reg})
        begin
            r_pos = '0;
        end
        else
        begin
            r_pos = r_wrap[ROW_W-1:0];
        end
        c_pos = c_wrap[COL_W-1:0];

        // Advance to the following pixel position.
        c_inc = {1'b0, c_pos} + 1'b1;
        r_inc = {1'b0, r_pos} + 1'b1;
        if (c_inc >= w_eff_reg)
        begin
            col_next = '0;
            row_next = (r_inc >= {1'b0, h_eff_reg}) ? '0 : r_inc[ROW_W-1:0];
        end
        else
        begin
            col_next = c_inc[COL_W-1:0];
            row_next = r_pos;
        end

        hiwater_next = (c_inc > hiwater_reg) ? c_inc : hiwater_reg;
        res_flag  = (32'(r_pos) >= 2) && (32'(c_pos) >= 2);
        last_flag = (r_pos == h_eff_reg - 1'b1) && ({1'b0, c_pos} == w_eff_reg - 1'b1);
        entry_ok  = {1'b0, c_pos} < hiwater_reg;
        // The item leaving stage one writes this same entry at this edge.
        fwd_hit   = v1_reg && (c_pos == c1_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            hiwater_reg <= '0;
        end
        else if (accept)
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            hiwater_reg <= hiwater_next;
        end
    end

    // Stage one: line store read data, bypass and the column window.
    logic [PIX_W-1:0]   cur1_reg;
    logic               res1_reg, last1_reg, ok1_reg, fwd1_reg;
    logic [2*PIX_W-1:0] fwd_data_reg;
    logic [2*PIX_W-1:0] ram_rdata;
    logic [PIX_W-1:0]   up_s1, mid_s1;
    logic [PIX_W-1:0]   win_reg [0:5];

    always_comb
    begin
        if (fwd1_reg)
        begin
            {up_s1, mid_s1} = fwd_data_reg;
        end
        else if (ok1_reg)
        begin
            {up_s1, mid_s1} = ram_rdata;
        end
        else
        begin
            up_s1  = '0;
            mid_s1 = '0;
        end
    end

    sgd_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) line_ram (
        .clk   (clk),
        .we    (s1_leave),
        .waddr (c1_reg),
        .wdata ({mid_s1, cur1_reg}),
        .re    (accept),
        .raddr (c_pos),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            fwd1_reg <= 1'b0;
        end
        else if (load1)
        begin
            v1_reg   <= accept;
            fwd1_reg <= accept && fwd_hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            c1_reg       <= c_pos;
            cur1_reg     <= pixels.pixel;
            res1_reg     <= res_flag;
            last1_reg    <= last_flag;
            ok1_reg      <= entry_ok;
            fwd_data_reg <= {mid_s1, cur1_reg};
        end
        // The window shifts by one column for every item.
        if (s1_leave)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= up_s1;
            win_reg[4] <= mid_s1;
            win_reg[5] <= cur1_reg;
        end
    end

    // Sobel sums, then division by four toward zero.
    logic [9:0]         gx_pos, gx_neg, gy_pos, gy_neg;
    logic signed [10:0] gx_raw, gy_raw, gx_q, gy_q;
    logic signed [8:0]  gx2_reg, gy2_reg;
    logic               last2_reg;

    always_comb
    begin
        gx_pos = {2'b0, up_s1} + {1'b0, mid_s1, 1'b0} + {2'b0, cur1_reg};
        gx_neg = {2'b0, win_reg[0]} + {1'b0, win_reg[1], 1'b0} + {2'b0, win_reg[2]};
        gy_pos = {2'b0, win_reg[2]} + {1'b0, win_reg[5], 1'b0} + {2'b0, cur1_reg};
        gy_neg = {2'b0, win_reg[0]} + {1'b0, win_reg[3], 1'b0} + {2'b0, up_s1};
        gx_raw = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
        gy_raw = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
        gx_q   = gx_raw[10] ? ((gx_raw + 11'sd3) >>> 2) : (gx_raw >>> 2);
        gy_q   = gy_raw[10] ? ((gy_raw + 11'sd3) >>> 2) : (gy_raw >>> 2);
    end

    // Stage two: magnitudes, squares and the sector thresholds.
    logic [8:0]       gx_abs, gy_abs;
    logic [PIX_W-1:0] ax, ay;
    logic [SQ_W-1:0]  sqx3_reg, sqy3_reg;
    logic [P22_W-1:0] p22_3_reg;
    logic [P67_W-1:0] p67_3_reg;
    logic [PIX_W-1:0] ay3_reg;
    logic             gxpos3_reg, gypos3_reg, zero3_reg, last3_reg;

    always_comb
    begin
        gx_abs = gx2_reg[8] ? 9'(-gx2_reg) : 9'(gx2_reg);
        gy_abs = gy2_reg[8] ? 9'(-gy2_reg) : 9'(gy2_reg);
        ax     = gx_abs[PIX_W-1:0];
        ay     = gy_abs[PIX_W-1:0];
    end

    // Stage three: sum of squares and the sector decision.
    logic [SUM_W-1:0] sum_sq;
    logic [LHS_W-1:0] lhs;
    logic [DIR_W-1:0] sector;
    sqrt_t            acc4_reg, acc5_reg, acc6_reg, acc_out;
    logic [DIR_W-1:0] dir4_reg, dir5_reg, dir6_reg, dir7_reg;
    logic             last4_reg, last5_reg, last6_reg, last7_reg;
    logic [MAG_W-1:0] mag7_reg;

    always_comb
    begin
        sum_sq = SUM_W'(sqx3_reg) + SUM_W'(sqy3_reg);
        lhs    = {ay3_reg, 16'b0};
        if (zero3_reg)
        begin
            sector = SECTOR_E;
        end
        else if (P67_W'(lhs) < P67_W'(p22_3_reg))
        begin
            sector = gxpos3_reg ? SECTOR_E : SECTOR_W;
        end
        else if (P67_W'(lhs) > p67_3_reg)
        begin
            sector = gypos3_reg ? SECTOR_N : SECTOR_S;
        end
        else if (gxpos3_reg)
        begin
            sector = gypos3_reg ? SECTOR_NE : SECTOR_SE;
        end
        else
        begin
            sector = gypos3_reg ? SECTOR_NW : SECTOR_SW;
        end
    end

    // Last root digits; saturation to the output range is applied as stage seven loads.
    always_comb
    begin
        acc_out = sqrt_steps(acc6_reg, 6);
    end

    // Valid bits of stages two to seven; only items with a result travel on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            if (load2)
            begin
                v2_reg <= v1_reg && res1_reg;
            end
            if (load3)
            begin
                v3_reg <= v2_reg;
            end
            if (load4)
            begin
                v4_reg <= v3_reg;
            end
            if (load5)
            begin
                v5_reg <= v4_reg;
            end
            if (load6)
            begin
                v6_reg <= v5_reg;
            end
            if (load7)
            begin
                v7_reg <= v6_reg;
            end
        end
    end

    // Payload of stages two to seven.
    always_ff @(posedge clk)
    begin
        if (load2)
        begin
            gx2_reg   <= gx_q[8:0];
            gy2_reg   <= gy_q[8:0];
            last2_reg <= last1_reg;
        end
        if (load3)
        begin
            sqx3_reg   <= SQ_W'(ax) * SQ_W'(ax);
            sqy3_reg   <= SQ_W'(ay) * SQ_W'(ay);
            p22_3_reg  <= P22_W'(ax) * P22_W'(TAN22_Q16);
            p67_3_reg  <= P67_W'(ax) * P67_W'(TAN67_Q16);
            ay3_reg    <= ay;
            gxpos3_reg <= !gx2_reg[8] && (gx2_reg != '0);
            gypos3_reg <= !gy2_reg[8] && (gy2_reg != '0);
            zero3_reg  <= (gx2_reg == '0) && (gy2_reg == '0);
            last3_reg  <= last2_reg;
        end
        if (load4)
        begin
            acc4_reg.rem  <= sum_sq;
            acc4_reg.root <= '0;
            dir4_reg      <= sector;
            last4_reg     <= last3_reg;
        end
        if (load5)
        begin
            acc5_reg  <= sqrt_steps(acc4_reg, 0);
            dir5_reg  <= dir4_reg;
            last5_reg <= last4_reg;
        end
        if (load6)
        begin
            acc6_reg  <= sqrt_steps(acc5_reg, 3);
            dir6_reg  <= dir5_reg;
            last6_reg <= last5_reg;
        end
        if (load7)
        begin
            mag7_reg  <= (acc_out.root > SUM_W'(255)) ? {MAG_W{1'b1}}
                                                      : acc_out.root[MAG_W-1:0];
            dir7_reg  <= dir6_reg;
            last7_reg <= last6_reg;
        end
    end

    // Result channel.
    assign results.valid         = v7_reg;
    assign results.magnitude     = mag7_reg;
    assign results.direction     = dir7_reg;
    assign results.last_of_frame = last7_reg;

    // The fill mark never passes the line store depth.
    `SGD_ASSERT_IMPLIES(a_hiwater_bound, clk, rst_n, 1'b1, hiwater_reg <= EW'(MAX_WIDTH))
    // After an item the column counter lies inside the current row.
    `SGD_ASSERT_NEXT(a_col_in_row, clk, rst_n, accept && !cfg_we, (32'(col_reg) < 32'(w_eff_reg)))
    // A bypassed read always has the item that wrote it just ahead in stage one.
    `SGD_ASSERT_NEXT(a_fwd_writer, clk, rst_n, accept && fwd_hit, fwd1_reg && v1_reg)

endmodule

// ===== bench/sobel_gradient_direction_tb.sv =====
// Self-checking testbench for the Sobel gradient block: random pixel frames against a predictor.
module sobel_gradient_direction_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sgd_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 12;
    localparam int IDLE_PCT      = 36;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_REPORTS   = 10;
    localparam int ALL_ROWS      = 1 << ROW_W;
    localparam int SOBEL_SCALE   = 4;

    // Direction sectors, counterclockwise from the +gx axis.
    typedef enum logic [DIR_W-1:0] {
        SECTOR_E  = 3'd0,
        SECTOR_NE = 3'd1,
        SECTOR_N  = 3'd2,
        SECTOR_NW = 3'd3,
        SECTOR_W  = 3'd4,
        SECTOR_SW = 3'd5,
        SECTOR_S  = 3'd6,
        SECTOR_SE = 3'd7
    } sector_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } pixel_item_t;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic [DIR_W-1:0] direction;
        logic             last_of_frame;
    } gradient_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    sgd_pixel_if  pix_if ();
    sgd_result_if res_if ();

    sobel_gradient_direction dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixels    (pix_if),
        .results   (res_if)
    );

    // Pixels waiting to be sent and gradients waiting to come back.
    pixel_item_t pixel_q[$];
    gradient_t   gradient_q[$];
    int unsigned gradient_errors = 0;
    int unsigned cycle_count     = 0;
    bit          steady          = 1'b0;

    // Predictor copy of the line stores, window, position and geometry.
    logic [PIX_W-1:0]   upper_row  [MAX_WIDTH] = '{default: '0};
    logic [PIX_W-1:0]   middle_row [MAX_WIDTH] = '{default: '0};
    logic [PIX_W-1:0]   window_px  [6]         = '{default: '0};
    int unsigned        col_pos    = 0;
    int unsigned        row_pos    = 0;
    logic [IMG_W_W-1:0] width_reg  = IMG_W_W'(IMG_W_RESET);
    logic [ROW_W-1:0]   height_reg = ROW_W'(IMG_H_RESET);

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic int unsigned active_width(logic [IMG_W_W-1:0] value);
        if (value < MIN_SIDE)
            return MIN_SIDE;
        if (value > MAX_WIDTH)
            return MAX_WIDTH;
        return 32'(value);
    endfunction

    function automatic int unsigned active_height(logic [ROW_W-1:0] value);
        return (value < MIN_SIDE) ? MIN_SIDE : 32'(value);
    endfunction

    // Floor of the square root, clipped to the magnitude range.
    function automatic logic [MAG_W-1:0] saturated_root(int unsigned value);
        int unsigned root;
        root = 0;
        while (root < (1 << MAG_W) - 1 && (root + 1) * (root + 1) <= value)
            root++;
        return root[MAG_W-1:0];
    endfunction

    // Sector from |gy| against |gx| scaled by tan(22.5) and tan(67.5), plus the signs.
    function automatic sector_t sector_of_gradient(int gx, int gy);
        int unsigned abs_x;
        int unsigned abs_y;
        int unsigned scaled_y;
        abs_x = (gx < 0) ? -gx : gx;
        abs_y = (gy < 0) ? -gy : gy;
        scaled_y = abs_y << 16;
        if (abs_x == 0 && abs_y == 0)
            return SECTOR_E;
        if (scaled_y < abs_x * TAN22_Q16)
            return (gx > 0) ? SECTOR_E : SECTOR_W;
        if (scaled_y > abs_x * TAN67_Q16)
            return (gy > 0) ? SECTOR_N : SECTOR_S;
        if (gx > 0)
            return (gy > 0) ? SECTOR_NE : SECTOR_SE;
        return (gy > 0) ? SECTOR_NW : SECTOR_SW;
    endfunction

    // Advances the predictor by one accepted pixel and queues its gradient, if any.
    task automatic predict_gradient(logic [PIX_W-1:0] px, logic first);
        int unsigned      w;
        int unsigned      h;
        int unsigned      c;
        int unsigned      r;
        int               sum_left;
        int               sum_right;
        int               sum_top;
        int               sum_bottom;
        int               gx;
        int               gy;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] mid;
        gradient_t        grad;

        w = active_width(width_reg);
        h = active_height(height_reg);

        // A frame mark restarts the raster; a shrunk geometry folds the position back.
        if (first)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h)
            row_pos = 0;

        c = col_pos;
        r = row_pos;
        up = upper_row[c];
        mid = middle_row[c];

        // The pixel closes the window centred one row up and one column left.
        if (r >= 2 && c >= 2)
        begin
            sum_left   = window_px[0] + 2 * window_px[1] + window_px[2];
            sum_right  = up + 2 * mid + px;
            sum_top    = window_px[0] + 2 * window_px[3] + up;
            sum_bottom = window_px[2] + 2 * window_px[5] + px;
            gx = (sum_right - sum_left) / SOBEL_SCALE;
            gy = (sum_bottom - sum_top) / SOBEL_SCALE;
            grad.magnitude = saturated_root(gx * gx + gy * gy);
            grad.direction = sector_of_gradient(gx, gy);
            grad.last_of_frame = (r == h - 1) && (c == w - 1);
            gradient_q.push_back(grad);
        end

        upper_row[c] = mid;
        middle_row[c] = px;
        window_px[0] = window_px[3];
        window_px[1] = window_px[4];
        window_px[2] = window_px[5];
        window_px[3] = up;
        window_px[4] = mid;
        window_px[5] = px;

        col_pos = c + 1;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h)
                row_pos = 0;
        end
    endtask

    // Mix of hard edges, dark and bright patches and plain noise.
    function automatic logic [PIX_W-1:0] random_pixel();
        case ($urandom_range(3))
            0: return $urandom_range(1) ? '1 : '0;
            1: return PIX_W'($urandom_range(15));
            2: return PIX_W'($urandom_range(255, 240));
            default: return PIX_W'($urandom_range(255));
        endcase
    endfunction

    task automatic queue_pixel(logic [PIX_W-1:0] px, logic first);
        pixel_item_t item;
        item.pixel = px;
        item.frame_start = first;
        pixel_q.push_back(item);
    endtask

    // Waits until every pixel is taken and every gradient is back, then lets the pipe settle.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pixel_q.size() != 0 || pix_if.valid || gradient_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(cfg_index_t index, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        if (index == CFG_IMAGE_WIDTH)
            width_reg = value[IMG_W_W-1:0];
        else
            height_reg = value[ROW_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // One geometry: several frames, some unmarked or cut short, then loose pixels.
    task automatic run_phase(logic [CFG_DATA_W-1:0] w_val, logic [CFG_DATA_W-1:0] h_val,
                             int frames, int unsigned row_cap);
        int unsigned cols;
        int unsigned rows;
        int unsigned len;
        int          f;
        int unsigned i;
        bit          mark;

        wait_drained();
        write_reg(CFG_IMAGE_WIDTH, w_val);
        write_reg(CFG_IMAGE_HEIGHT, h_val);
        @(negedge clk);

        cols = active_width(w_val[IMG_W_W-1:0]);
        rows = active_height(h_val[ROW_W-1:0]);
        if (rows > row_cap)
            rows = row_cap;

        for (f = 0; f < frames; f++)
        begin
            len = rows * cols;
            if ($urandom_range(7) == 0)
                len = $urandom_range(len, 1);
            mark = ($urandom_range(3) != 0);
            for (i = 0; i < len; i++)
                queue_pixel(random_pixel(), mark && i == 0);
        end

        len = $urandom_range(12);
        for (i = 0; i < len; i++)
            queue_pixel(random_pixel(), $urandom_range(19) == 0);
    endtask

    // Pixel sender: predicts on each accepted item, then offers the next one or idles.
    always @(posedge clk or negedge rst_n)
    begin : send_pixels
        pixel_item_t item;
        if (!rst_n)
        begin
            pix_if.valid <= 1'b0;
            pix_if.pixel <= '0;
            pix_if.frame_start <= 1'b0;
        end
        else
        begin
            if (pix_if.valid && pix_if.ready)
                predict_gradient(pix_if.pixel, pix_if.frame_start);
            if (!pix_if.valid || pix_if.ready)
            begin
                if (pixel_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    item = pixel_q.pop_front();
                    pix_if.valid <= 1'b1;
                    pix_if.pixel <= item.pixel;
                    pix_if.frame_start <= item.frame_start;
                end
                else
                begin
                    pix_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: random stalls, every accepted item checked against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : collect_results
        gradient_t got;
        gradient_t want;
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
        end
        else
        begin
            res_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            if (res_if.valid && res_if.ready)
            begin
                got.magnitude = res_if.magnitude;
                got.direction = res_if.direction;
                got.last_of_frame = res_if.last_of_frame;
                if (gradient_q.size() == 0)
                begin
                    gradient_errors++;
                    if (gradient_errors <= MAX_REPORTS)
                        $display("%0t: unexpected result: magnitude %0d direction %0d last %0d",
                                 $time, got.magnitude, got.direction, got.last_of_frame);
                end
                else
                begin
                    want = gradient_q.pop_front();
                    if (got.magnitude !== want.magnitude || got.direction !== want.direction ||
                        got.last_of_frame !== want.last_of_frame)
                    begin
                        gradient_errors++;
                        if (gradient_errors <= MAX_REPORTS)
                            $display({"%0t: result mismatch: expected magnitude %0d direction %0d",
                                      " last %0d, got magnitude %0d direction %0d last %0d"},
                                     $time, want.magnitude, want.direction, want.last_of_frame,
                                     got.magnitude, got.direction, got.last_of_frame);
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("sobel_gradient_direction test failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [PIX_W-1:0] probe [30];
        int               n;

        rst_n = 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_data <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed frame three pixels wide: a left-to-right ramp, the reversed ramp, a bright
        // row into a dark band (steep downward gradient), a flat dark patch, and a small step
        // that only rounding toward zero brings back to a zero gradient on the last pixel.
        write_reg(CFG_IMAGE_WIDTH, 12'd3);
        write_reg(CFG_IMAGE_HEIGHT, 12'd10);
        @(negedge clk);
        probe = '{8'd0,   8'd128, 8'd255,
                  8'd0,   8'd128, 8'd255,
                  8'd0,   8'd128, 8'd255,
                  8'd255, 8'd128, 8'd0,
                  8'd255, 8'd128, 8'd0,
                  8'd255, 8'd128, 8'd0,
                  8'd255, 8'd255, 8'd255,
                  8'd0,   8'd0,   8'd0,
                  8'd0,   8'd0,   8'd0,
                  8'd3,   8'd0,   8'd0};
        for (n = 0; n < 30; n++)
            queue_pixel(probe[n], n == 0);

        // Small geometries, including register values below the minimum side.
        run_phase(12'd4, 12'd3, 10, ALL_ROWS);
        run_phase(12'd5, 12'd4, 6, ALL_ROWS);
        run_phase(12'd0, 12'd1, 10, ALL_ROWS);
        run_phase(12'd2, 12'd2, 6, ALL_ROWS);
        run_phase(12'd9, 12'd7, 3, ALL_ROWS);
        run_phase(12'd16, 12'd3, 3, ALL_ROWS);

        // Tallest height: frames are restarted long before the bottom row.
        run_phase(12'd3, 12'hFFF, 3, 20);
        run_phase(12'd6, 12'd0, 6, ALL_ROWS);
        run_phase(12'd12, 12'd10, 1, ALL_ROWS);

        // Wider rows, written with a stray bit above the width field, with no idling on
        // either side.
        steady = 1'b1;
        run_phase(12'h830, 12'd4, 1, ALL_ROWS);
        wait_drained();
        steady = 1'b0;

        run_phase(12'd7, 12'd5, 4, ALL_ROWS);
        run_phase(CFG_DATA_W'($urandom_range(10, 3)), CFG_DATA_W'($urandom_range(6, 3)), 4,
                  ALL_ROWS);

        wait_drained();
        if (gradient_errors == 0 && gradient_q.size() == 0)
            $display("sobel_gradient_direction test passed");
        else
            $display("sobel_gradient_direction test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/sgd_pkg.sv
hw/rtl/sgd_ifs.sv
hw/rtl/sgd_ram.sv
hw/rtl/sobel_gradient_direction.sv
bench/sobel_gradient_direction_tb.sv
